[rtl/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// tfd_pkg
// Types, protocol constants and helper functions shared by the deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h78;
    localparam logic [7:0]  STOP1_BYTE  = 8'h0D;
    localparam logic [7:0]  STOP2_BYTE  = 8'h0A;
    localparam logic [7:0]  TYPE_LOGIN  = 8'h01;
    localparam logic [7:0]  TYPE_LOCATE = 8'h10;
    localparam logic [7:0]  TYPE_HBEAT  = 8'h23;
    localparam logic [7:0]  MIN_LENGTH  = 8'd5;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam int          STORE_DEPTH = 19;
    localparam int          IDX_W       = 5;

    localparam logic [1:0] KIND_LOGIN  = 2'd0;
    localparam logic [1:0] KIND_LOCATE = 2'd1;
    localparam logic [1:0] KIND_HBEAT  = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_TYPE,
        PH_CONTENT,
        PH_SERHI,
        PH_SERLO,
        PH_CRCHI,
        PH_CRCLO,
        PH_STOP1,
        PH_STOP2
    } t_phase;

    typedef struct packed {
        logic [3:0]         satellites;
        logic               fix_valid;
        logic signed [32:0] longitude_units;
        logic signed [32:0] latitude_units;
        logic [43:0]        utc_ms;
        logic [63:0]        imei_bcd;
        logic [8:0]         frame_length;
        logic [15:0]        serial;
        logic [1:0]         kind;
        logic               status;
    } t_result;

    // One byte of CRC-16/X-25, reflected, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Day of year at the first of a March-based month index.
    function automatic logic [8:0] month_doy(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/tfd_epoch.sv]
// ----------------------------------------------------------------------------
// tfd_epoch
// Converts the six date and time content bytes into epoch milliseconds, one
// short step per arriving content byte.
// ----------------------------------------------------------------------------
module tfd_epoch (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tfd_pkg::IDX_W-1:0] i_idx,
    input  logic [7:0]                i_byte,
    output logic [43:0]               o_ms
);
    import tfd_pkg::*;

    logic [7:0]  r_year_b, r_day_b, r_hour_b, r_min_b;
    logic [11:0] r_yy;
    logic [3:0]  r_mp;
    logic [16:0] r_base, r_days;
    logic [33:0] r_dsec, r_secs;
    logic [19:0] r_hms;
    logic [43:0] r_ms;

    logic [7:0]  mon_m1;
    logic [15:0] q_prod;
    logic [4:0]  q;
    logic [3:0]  mon0;
    logic [11:0] year;
    logic [11:0] n_yy;
    logic [3:0]  n_mp;
    logic        era5;
    logic [8:0]  yoe;
    logic [1:0]  cent;
    logic signed [20:0] base_s;

    // Month byte: fold the month into the year (month zero is December of
    // the year before), then move to a March-based year.
    always_comb begin
        mon_m1 = i_byte - 8'd1;
        q_prod = 16'(mon_m1) * 16'd171;
        q      = q_prod[15:11];
        if (i_byte == 8'd0) begin
            year = 12'd1999 + 12'(r_year_b);
            mon0 = 4'd11;
        end else begin
            year = 12'd2000 + 12'(r_year_b) + 12'(q);
            mon0 = 4'(mon_m1 - 8'(q) * 8'd12);
        end
        n_yy = (mon0 <= 4'd1) ? year - 12'd1 : year;
        n_mp = (mon0 >= 4'd2) ? mon0 - 4'd2 : mon0 + 4'd10;
    end

    // Days from 1970-01-01 to the first of the month.
    always_comb begin
        era5 = (r_yy >= 12'd2000);
        yoe  = era5 ? 9'(r_yy - 12'd2000) : 9'(r_yy - 12'd1600);
        if (yoe >= 9'd300)      cent = 2'd3;
        else if (yoe >= 9'd200) cent = 2'd2;
        else if (yoe >= 9'd100) cent = 2'd1;
        else                    cent = 2'd0;
        base_s = (era5 ? 21'sd11017 : -21'sd135080)
               + $signed({3'b000, 18'(yoe) * 18'd365})
               + $signed({14'd0, yoe[8:2]})
               - $signed({19'd0, cent})
               + $signed({12'd0, month_doy(r_mp)});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (i_idx)
                5'd0: r_year_b <= i_byte;
                5'd1: begin
                    r_yy <= n_yy;
                    r_mp <= n_mp;
                end
                5'd2: begin
                    r_base  <= base_s[16:0];
                    r_day_b <= i_byte;
                end
                5'd3: begin
                    r_days   <= r_base + 17'(r_day_b) - 17'd1;
                    r_hour_b <= i_byte;
                end
                5'd4: begin
                    r_dsec  <= 34'(r_days) * 34'd86400;
                    r_min_b <= i_byte;
                end
                5'd5: r_hms  <= 20'(r_hour_b) * 20'd3600 + 20'(r_min_b) * 20'd60
                              + 20'(i_byte);
                5'd6: r_secs <= r_dsec + 34'(r_hms);
                5'd7: r_ms   <= 44'(r_secs) * 44'd1000;
                default: ;
            endcase
        end
    end

    assign o_ms = r_ms;

endmodule

[rtl/tracker_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// tracker_frame_deframer_top
// Byte-serial deframer for tracker link frames with a CRC-16/X-25 check.
// ----------------------------------------------------------------------------
// Usage: bytes of the link stream enter on the s_axis channel, one byte per
// transfer. The block hunts for the 0x78 0x78 start pair, then reads length,
// type, content, serial, checksum and the two stop bytes. Bytes outside a
// frame are dropped. After the last stop byte, or right after a length byte
// below five, one result leaves on the m_axis channel; every other byte gives
// no result.
// The result is registered on the transfer of the byte that completes it and
// is presented in the cycle after. Throughput: one byte per cycle while the
// output is not stalled. The per-byte work is a CRC update and a capture;
// the date conversion runs as a short pipeline stepped by the content bytes,
// so it is done well before the frame ends. A single output register holds
// the result. While it is full and the receiver stalls, s_axis_tready is low;
// once the result is taken in the same cycle, a new byte is accepted.
// Reset (i_rst_n low at a clock edge) returns the block to hunting for a
// start byte and empties the output register.
// ----------------------------------------------------------------------------
module tracker_frame_deframer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] serial, [24:16] frame_length, [88:25] imei_bcd,
    // [132:89] utc_ms, [165:133] latitude_units,
    // [198:166] longitude_units, [199] fix_valid, [203:200] satellites,
    // [207:204] zero
    output logic [207:0] m_axis_tdata,
    // [0] status, [2:1] kind
    output logic [2:0]   m_axis_tuser
);
    import tfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len;
    logic [7:0]  r_cnt;
    logic [15:0] r_crc;
    logic [7:0]  r_type;
    logic [7:0]  r_store [STORE_DEPTH];
    logic [15:0] r_serial;
    logic [15:0] r_rx_crc;
    logic        r_stop1_ok;
    logic        r_out_valid;
    t_result     r_out;

    logic        accept;
    logic        emit;
    t_result     res;
    logic [7:0]  b;
    logic        ep_en;
    logic [43:0] ep_ms;
    logic [7:0]  n_cnt;

    assign b      = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign n_cnt  = r_cnt + 8'd1;

    // Content bytes past the stored window still go through the CRC.
    assign ep_en = accept && (r_phase == PH_CONTENT) && (r_cnt < 8'(STORE_DEPTH));

    tfd_epoch u_epoch (
        .i_clk  (i_clk),
        .i_en   (ep_en),
        .i_idx  (r_cnt[IDX_W-1:0]),
        .i_byte (b),
        .o_ms   (ep_ms)
    );

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT1:   if (b == START_BYTE) n_phase = PH_HUNT2;
            PH_HUNT2:   n_phase = (b == START_BYTE) ? PH_LEN : PH_HUNT1;
            PH_LEN:     n_phase = (b < MIN_LENGTH) ? PH_HUNT1 : PH_TYPE;
            PH_TYPE:    n_phase = (r_len == MIN_LENGTH) ? PH_SERHI : PH_CONTENT;
            PH_CONTENT: if (n_cnt >= r_len - MIN_LENGTH) n_phase = PH_SERHI;
            PH_SERHI:   n_phase = PH_SERLO;
            PH_SERLO:   n_phase = PH_CRCHI;
            PH_CRCHI:   n_phase = PH_CRCLO;
            PH_CRCLO:   n_phase = PH_STOP1;
            PH_STOP1:   n_phase = PH_STOP2;
            PH_STOP2:   n_phase = PH_HUNT1;
            default:    n_phase = PH_HUNT1;
        endcase
    end

    // Result built from the captured frame and the current byte.
    always_comb begin
        logic        frame_ok;
        logic        bad;
        logic [15:0] flags;
        logic [32:0] lat_raw, lon_raw;
        res      = '0;
        emit     = 1'b0;
        bad      = 1'b0;
        frame_ok = r_stop1_ok && (b == STOP2_BYTE) && ((r_crc ^ CRC_INIT) == r_rx_crc);
        flags    = {r_store[17], r_store[18]};
        lat_raw  = {1'b0, r_store[8], r_store[9], r_store[10], r_store[11]};
        lon_raw  = {1'b0, r_store[12], r_store[13], r_store[14], r_store[15]};
        unique case (r_phase)
            PH_LEN: begin
                if (b < MIN_LENGTH) begin
                    emit             = 1'b1;
                    res.status       = STATUS_BAD;
                    res.frame_length = 9'(b) + 9'd5;
                end
            end
            PH_STOP2: begin
                emit = 1'b1;
                if (r_type == TYPE_LOGIN) begin
                    bad          = (r_len < 8'd13);
                    res.kind     = KIND_LOGIN;
                    res.imei_bcd = {r_store[0], r_store[1], r_store[2], r_store[3],
                                    r_store[4], r_store[5], r_store[6], r_store[7]};
                end else if (r_type == TYPE_LOCATE) begin
                    bad                 = (r_len < 8'd24) || (r_store[6] == 8'd0);
                    res.kind            = KIND_LOCATE;
                    res.utc_ms          = ep_ms;
                    res.latitude_units  = flags[10] ? $signed(lat_raw) : -$signed(lat_raw);
                    res.longitude_units = flags[11] ? -$signed(lon_raw) : $signed(lon_raw);
                    res.fix_valid       = flags[12];
                    res.satellites      = r_store[7][3:0];
                end else if (r_type == TYPE_HBEAT) begin
                    res.kind = KIND_HBEAT;
                end else begin
                    res.kind = KIND_OTHER;
                end
                res.serial = r_serial;
                if (!frame_ok || bad) begin
                    res        = '0;
                    res.status = STATUS_BAD;
                end
                res.frame_length = 9'(r_len) + 9'd5;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_crc   <= CRC_INIT;
        end else if (accept) begin
            r_phase <= n_phase;
            unique case (r_phase)
                PH_LEN: begin
                    r_len <= b;
                    r_cnt <= '0;
                    r_crc <= crc_byte(CRC_INIT, b);
                end
                PH_TYPE: begin
                    r_type <= b;
                    r_crc  <= crc_byte(r_crc, b);
                end
                PH_CONTENT: begin
                    r_cnt <= n_cnt;
                    r_crc <= crc_byte(r_crc, b);
                end
                PH_SERHI: begin
                    r_serial[15:8] <= b;
                    r_crc          <= crc_byte(r_crc, b);
                end
                PH_SERLO: begin
                    r_serial[7:0] <= b;
                    r_crc         <= crc_byte(r_crc, b);
                end
                PH_CRCHI: r_rx_crc[15:8] <= b;
                PH_CRCLO: r_rx_crc[7:0]  <= b;
                PH_STOP1: r_stop1_ok     <= (b == STOP1_BYTE);
                default: ;
            endcase
        end
    end

    // Content capture, one fixed register per content position.
    always_ff @(posedge i_clk) begin
        if (ep_en) begin
            r_store[r_cnt[IDX_W-1:0]] <= b;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.kind, r_out.status};
    assign m_axis_tdata  = {4'd0, r_out.satellites, r_out.fix_valid,
                            r_out.longitude_units, r_out.latitude_units,
                            r_out.utc_ms, r_out.imei_bcd,
                            r_out.frame_length, r_out.serial};

`ifndef ASSERT_OFF
    // A held result must block the input, or a second result would be lost.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a result is stalled");

    // A new result appears only after an input byte was taken.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted byte");

    // A rejected frame carries no kind and no serial.
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tuser[2:1] == KIND_LOGIN && m_axis_tdata[15:0] == 16'd0))
        else $error("invalid result with nonzero fields");
`endif

endmodule

[test/tb_tracker_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// tb_tracker_frame_deframer_top
// Self-checking testbench for the tracker frame deframer.
// ----------------------------------------------------------------------------
// Byte streams of whole frames, broken frames and line noise are pushed into
// the slave channel. A scoreboard class tracks the deframer state on every
// accepted byte and queues the frame report it expects. Every report taken
// from the master channel is compared field by field against the oldest
// queued one. The run walks through several idle and stall patterns on both
// sides, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tracker_frame_deframer_top;
    import tfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MODE_FREE      = 0;
    localparam int MODE_SRC_IDLE  = 1;
    localparam int MODE_SNK_STALL = 2;
    localparam int MODE_BOTH      = 3;

    typedef enum int {BAD_NONE, BAD_CRC, BAD_STOP1, BAD_STOP2} t_damage;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    int mode = MODE_FREE;
    int hold_cycles = 0;
    int idle_count = 0;
    int frame_bytes = 0;
    int frames_sent = 0;

    always #10 i_clk = ~i_clk;

    tracker_frame_deframer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Reflected CRC-16/X-25 update for one byte.
    function automatic logic [15:0] x25_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    class frame_scoreboard;
        t_phase      ph;
        logic [7:0]  len_v, cnt, typ;
        logic [15:0] crc, ser, rx_crc;
        logic [7:0]  store [STORE_DEPTH];
        logic        stop1_ok;
        t_result     reports [$];
        int          errors;
        int          checked;

        function new();
            ph = PH_HUNT1;
            len_v = 0; cnt = 0; typ = 0;
            crc = CRC_INIT; ser = 0; rx_crc = 0;
            stop1_ok = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function t_result bad_report(input logic [8:0] flen);
            t_result r;
            r = '0;
            r.status = STATUS_BAD;
            r.frame_length = flen;
            return r;
        endfunction

        // UTC milliseconds from YY MM DD hh mm ss, with calendar carry.
        function logic [43:0] stamp_ms();
            longint yr, m0, m, yy, era, yoe, mp, doy, doe, days, secs;
            yr = 2000 + longint'(store[0]);
            m0 = longint'(store[1]) - 1;
            if (m0 < 0) begin
                yr -= 1;
                m0 += 12;
            end else begin
                yr += m0 / 12;
                m0 = m0 % 12;
            end
            m = m0 + 1;
            yy = (m <= 2) ? yr - 1 : yr;
            era = yy / 400;
            yoe = yy - era * 400;
            mp = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468 + longint'(store[2]) - 1;
            secs = days * 86400 + longint'(store[3]) * 3600 + longint'(store[4]) * 60
                 + longint'(store[5]);
            return 44'(secs * 1000);
        endfunction

        function t_result close_frame(input logic [7:0] b);
            t_result r;
            logic [8:0]  flen;
            logic [15:0] flags;
            logic [32:0] lat, lon;
            flen = {1'b0, len_v} + 9'd5;
            if (!stop1_ok || b != STOP2_BYTE || (crc ^ 16'hFFFF) != rx_crc)
                return bad_report(flen);
            r = '0;
            r.serial = ser;
            r.frame_length = flen;
            if (typ == TYPE_LOGIN) begin
                if (len_v - 8'd5 < 8'd8)
                    return bad_report(flen);
                r.kind = KIND_LOGIN;
                for (int i = 0; i < 8; i++)
                    r.imei_bcd = {r.imei_bcd[55:0], store[i]};
            end else if (typ == TYPE_LOCATE) begin
                if (len_v - 8'd5 < 8'(STORE_DEPTH) || store[6] == 8'h00)
                    return bad_report(flen);
                flags = {store[17], store[18]};
                lat = {1'b0, store[8], store[9], store[10], store[11]};
                lon = {1'b0, store[12], store[13], store[14], store[15]};
                if (!flags[10])
                    lat = 33'd0 - lat;
                if (flags[11])
                    lon = 33'd0 - lon;
                r.kind = KIND_LOCATE;
                r.utc_ms = stamp_ms();
                r.latitude_units = lat;
                r.longitude_units = lon;
                r.fix_valid = flags[12];
                r.satellites = store[7][3:0];
            end else if (typ == TYPE_HBEAT) begin
                r.kind = KIND_HBEAT;
            end else begin
                r.kind = KIND_OTHER;
            end
            r.status = STATUS_OK;
            return r;
        endfunction

        // Advance the predicted deframer by one accepted byte.
        function void note_byte(input logic [7:0] b);
            case (ph)
                PH_HUNT1: if (b == START_BYTE) ph = PH_HUNT2;
                PH_HUNT2: ph = (b == START_BYTE) ? PH_LEN : PH_HUNT1;
                PH_LEN: begin
                    if (b < MIN_LENGTH) begin
                        ph = PH_HUNT1;
                        reports = {reports, bad_report({1'b0, b} + 9'd5)};
                    end else begin
                        len_v = b;
                        cnt = 0;
                        crc = x25_step(CRC_INIT, b);
                        ph = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    typ = b;
                    crc = x25_step(crc, b);
                    ph = (len_v == MIN_LENGTH) ? PH_SERHI : PH_CONTENT;
                end
                PH_CONTENT: begin
                    if (cnt < STORE_DEPTH)
                        store[cnt] = b;
                    crc = x25_step(crc, b);
                    cnt = cnt + 8'd1;
                    if (cnt >= len_v - 8'd5)
                        ph = PH_SERHI;
                end
                PH_SERHI: begin
                    ser = {b, 8'h00};
                    crc = x25_step(crc, b);
                    ph = PH_SERLO;
                end
                PH_SERLO: begin
                    ser[7:0] = b;
                    crc = x25_step(crc, b);
                    ph = PH_CRCHI;
                end
                PH_CRCHI: begin
                    rx_crc = {b, 8'h00};
                    ph = PH_CRCLO;
                end
                PH_CRCLO: begin
                    rx_crc[7:0] = b;
                    ph = PH_STOP1;
                end
                PH_STOP1: begin
                    stop1_ok = (b == STOP1_BYTE);
                    ph = PH_STOP2;
                end
                PH_STOP2: begin
                    ph = PH_HUNT1;
                    reports = {reports, close_frame(b)};
                end
                default: ph = PH_HUNT1;
            endcase
        endfunction

        function void check_report(input logic [207:0] d, input logic [2:0] u);
            t_result e;
            checked++;
            if (reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: tuser=%h tdata=%h", u, d);
                return;
            end
            e = reports.pop_front();
            if (u[0] !== e.status || u[2:1] !== e.kind || d[15:0] !== e.serial
                || d[24:16] !== e.frame_length || d[88:25] !== e.imei_bcd
                || d[132:89] !== e.utc_ms || d[165:133] !== e.latitude_units
                || d[198:166] !== e.longitude_units || d[199] !== e.fix_valid
                || d[203:200] !== e.satellites) begin
                errors++;
                if (errors <= 10) begin
                    $display("report %0d mismatch", checked);
                    $display("  exp st=%0d kd=%0d ser=%h len=%0d imei=%h",
                             e.status, e.kind, e.serial, e.frame_length, e.imei_bcd);
                    $display("      ts=%0d lat=%h lon=%h v=%0d s=%0d",
                             e.utc_ms, e.latitude_units, e.longitude_units,
                             e.fix_valid, e.satellites);
                    $display("  got st=%0d kd=%0d ser=%h len=%0d imei=%h",
                             u[0], u[2:1], d[15:0], d[24:16], d[88:25]);
                    $display("      ts=%0d lat=%h lon=%h v=%0d s=%0d",
                             d[132:89], d[165:133], d[198:166], d[199], d[203:200]);
                end
            end
        endfunction
    endclass

    frame_scoreboard sb = new();

    // Receiver: random stalls by mode, or a counted hold-off when requested.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_report(m_axis_tdata, m_axis_tuser);
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (mode == MODE_SNK_STALL) begin
            m_axis_tready <= ($urandom_range(99) >= 88);
        end else if (mode == MODE_BOTH) begin
            m_axis_tready <= ($urandom_range(99) >= 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count = 0;
        else
            idle_count = idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d reports pending", sb.reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ((mode == MODE_SRC_IDLE && $urandom_range(99) < 88)
               || (mode == MODE_BOTH && $urandom_range(99) < 9)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] typ, input logic [7:0] body [$],
                              input t_damage dmg);
        logic [7:0]  q [$];
        logic [15:0] c, ser;
        ser = 16'($urandom);
        q = {START_BYTE, START_BYTE, 8'(body.size() + 5), typ};
        q = {q, body};
        q = {q, ser[15:8], ser[7:0]};
        c = CRC_INIT;
        for (int i = 2; i < q.size(); i++) c = x25_step(c, q[i]);
        c = c ^ 16'hFFFF;
        if (dmg == BAD_CRC) c = c ^ (16'h1 << $urandom_range(15));
        q = {q, c[15:8], c[7:0]};
        q = {q, (dmg == BAD_STOP1) ? 8'h0C : STOP1_BYTE};
        q = {q, (dmg == BAD_STOP2) ? 8'h0B : STOP2_BYTE};
        foreach (q[i]) send_byte(q[i]);
        frame_bytes += q.size();
        frames_sent++;
    endtask

    task automatic send_short(input logic [7:0] len);
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(len);
        frame_bytes += 3;
        frames_sent++;
    endtask

    // Location content; wild dates leave the six calendar bytes random over all byte values.
    function automatic void fill_location(ref logic [7:0] body [$], input int n,
                                          input bit wild);
        body.delete();
        for (int i = 0; i < n; i++) body = {body, 8'($urandom)};
        if (!wild) begin
            body[0] = 8'($urandom_range(99));
            body[1] = 8'($urandom_range(12, 1));
            body[2] = 8'($urandom_range(28, 1));
            body[3] = 8'($urandom_range(23));
            body[4] = 8'($urandom_range(59));
            body[5] = 8'($urandom_range(59));
        end
        body[6] = 8'($urandom_range(255, 1));
    endfunction

    function automatic void fill_random(ref logic [7:0] body [$], input int n);
        body.delete();
        for (int i = 0; i < n; i++) body = {body, 8'($urandom)};
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_frame();
        logic [7:0] body [$];
        t_damage dmg;
        int r;
        r = $urandom_range(99);
        dmg = ($urandom_range(99) < 15) ? t_damage'($urandom_range(3, 1)) : BAD_NONE;
        if (r < 10) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end else if (r < 16) begin
            send_short(8'($urandom_range(4)));
        end else if (r < 36) begin
            fill_random(body, ($urandom_range(9) == 0) ? $urandom_range(12) : 8);
            send_frame(TYPE_LOGIN, body, dmg);
        end else if (r < 66) begin
            fill_location(body, ($urandom_range(9) == 0) ? $urandom_range(24, 17) : 19,
                          $urandom_range(4) == 0);
            if ($urandom_range(19) == 0) body[6] = 8'h00;
            send_frame(TYPE_LOCATE, body, dmg);
        end else if (r < 80) begin
            fill_random(body, $urandom_range(4));
            send_frame(TYPE_HBEAT, body, dmg);
        end else begin
            fill_random(body, ($urandom_range(29) == 0) ? 30 : $urandom_range(10));
            send_frame(8'($urandom), body, dmg);
        end
    endtask

    initial begin
        logic [7:0] body [$];
        int goal;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: line noise, a broken start pair and the short lengths.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'h55);
        send_short(8'd0);
        send_short(8'd4);
        // Shortest frame: no content at all.
        fill_random(body, 0);
        send_frame(TYPE_HBEAT, body, BAD_NONE);
        fill_random(body, 8);
        send_frame(TYPE_LOGIN, body, BAD_NONE);
        fill_random(body, 7);
        send_frame(TYPE_LOGIN, body, BAD_NONE);
        // Location with each hemisphere combination.
        for (int i = 0; i < 4; i++) begin
            fill_location(body, 19, 0);
            body[17] = {3'b000, 1'b1, i[1:0], 2'b00};
            send_frame(TYPE_LOCATE, body, BAD_NONE);
        end
        // Calendar carry: month zero and day zero, then all-ones and all-zero dates.
        fill_location(body, 19, 0);
        body[1] = 8'd0;
        body[2] = 8'd0;
        send_frame(TYPE_LOCATE, body, BAD_NONE);
        fill_location(body, 19, 0);
        for (int i = 0; i < 6; i++) body[i] = 8'hFF;
        send_frame(TYPE_LOCATE, body, BAD_NONE);
        fill_location(body, 19, 0);
        for (int i = 0; i < 6; i++) body[i] = 8'h00;
        send_frame(TYPE_LOCATE, body, BAD_NONE);
        fill_location(body, 19, 0);
        body[6] = 8'h00;
        send_frame(TYPE_LOCATE, body, BAD_NONE);
        fill_location(body, 18, 0);
        send_frame(TYPE_LOCATE, body, BAD_NONE);
        fill_random(body, 2);
        send_frame(TYPE_HBEAT, body, BAD_CRC);
        send_frame(TYPE_HBEAT, body, BAD_STOP1);
        send_frame(TYPE_HBEAT, body, BAD_STOP2);
        // Longest frame, with content past the stored part.
        fill_random(body, 250);
        send_frame(8'hFF, body, BAD_NONE);
        wait_drained();

        // Long receiver hold-off while short frames keep coming in.
        hold_cycles = 400;
        repeat (20) send_short(8'($urandom_range(4)));
        wait_drained();

        for (int m = MODE_FREE; m <= MODE_BOTH; m++) begin
            mode = m;
            goal = frame_bytes + 60;
            while (frame_bytes < goal) random_frame();
            wait_drained();
        end

        mode = MODE_FREE;
        s_axis_tvalid <= 1'b0;
        while (sb.reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d frames in %0d frame bytes, %0d reports checked, %0d errors",
                 frames_sent, frame_bytes, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/tfd_pkg.sv
rtl/tfd_epoch.sv
rtl/tracker_frame_deframer_top.sv
test/tb_tracker_frame_deframer_top.sv
